FILE: src/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared state, operation and status types for the exponentiation sequencer
// and its modular multiplier.
// ----------------------------------------------------------------------------
package mexp_pkg;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_MUL    = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_FINISH = 4'b1000
	} mexp_state_t;

	typedef enum logic [1:0] {
		OP_REDUCE = 2'd0,
		OP_MULR   = 2'd1,
		OP_SQUARE = 2'd2
	} mexp_op_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_status_t;

endpackage

FILE: src/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// Iterative modular multiplier
// Interleaved shift-add multiplication: one multiplier bit per cycle, each
// step doubling the accumulator, adding the addend and reducing by one or two
// subtractions of the modulus.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
	parameter int W = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [W-1:0]              mul_a,
	input  logic [W-1:0]              mul_addend,
	input  logic [W:0]                mod_ext,
	output mexp_pkg::mul_status_t     status,
	output logic [W-1:0]              result
);
	import mexp_pkg::*;

	localparam int CW = (W > 1) ? $clog2(W) : 1;

	logic [W-1:0] a_q;
	logic [W-1:0] addend_q;
	logic [W:0]   mod_q;
	logic [W-1:0] acc_q;
	logic [CW-1:0] cnt_q;
	logic         busy_q;
	logic         done_q;

	logic [W+1:0] sum;
	logic [W+2:0] diff1;
	logic [W+2:0] diff2;
	logic [W-1:0] step;

	always_comb begin
		sum   = {1'b0, acc_q, 1'b0} + (a_q[W-1] ? {2'b00, addend_q} : {(W+2){1'b0}});
		diff1 = {1'b0, sum} - {2'b00, mod_q};
		diff2 = {1'b0, sum} - {1'b0, mod_q, 1'b0};
		if (!diff2[W+2]) begin
			step = diff2[W-1:0];
		end else if (!diff1[W+2]) begin
			step = diff1[W-1:0];
		end else begin
			step = sum[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && cnt_q == '0) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q      <= mul_a;
			addend_q <= mul_addend;
			mod_q    <= mod_ext;
			acc_q    <= '0;
			cnt_q    <= CW'(W - 1);
		end else if (busy_q) begin
			acc_q <= step;
			a_q   <= {a_q[W-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign result      = acc_q;

endmodule

FILE: src/modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Right-to-left square and multiply over a shared iterative modular
// multiplier, with a result register toward the output channel.
// ----------------------------------------------------------------------------
// One transaction computes base_value to the power exponent_value modulo the
// configured modulus, all operands taken at their low OPERAND_WIDTH bits. A
// modulus of zero means 2 to the OPERAND_WIDTH, and an exponent of zero gives
// 1. Each modular multiplication runs in the single shift-add multiplier. A
// new transaction is taken only while the sequencer is idle; a finished
// result may wait in the output register meanwhile. The modulus is to be
// written only while the block is idle; the block itself does not enforce it.
module modular_exponentiation_top #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] modulus,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] base_value,
	input  logic [31:0] exponent_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] power_result
);
	import mexp_pkg::*;

	localparam int W = OPERAND_WIDTH;

	mexp_state_t state_q;
	mexp_op_t    op_q;
	logic [31:0] modulus_q;
	logic [W-1:0] exp_q;
	logic [W-1:0] r_q;
	logic [W-1:0] b_q;
	logic        out_valid_q;
	logic [31:0] out_data_q;

	logic [W-1:0] mod_w;
	logic [W:0]   mod_ext;
	logic [W-1:0] one_red;
	logic         accept;
	logic         mul_start;
	logic [W-1:0] mul_a;
	logic [W-1:0] mul_addend;
	logic [W-1:0] mul_result;
	mul_status_t  mul_status;
	logic         load_out;

	assign mod_w   = modulus_q[W-1:0];
	assign mod_ext = (mod_w == '0) ? {1'b1, {W{1'b0}}} : {1'b0, mod_w};
	assign one_red = (mod_ext == (W+1)'(1)) ? '0 : W'(1);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign load_out  = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		mul_start = 1'b0;
		unique case (state_q)
			ST_IDLE:   mul_start = accept;
			ST_MUL:    mul_start = mul_status.done && (op_q == OP_MULR);
			ST_SCAN:   mul_start = (exp_q != '0);
			ST_FINISH: mul_start = 1'b0;
			default:   mul_start = 1'b0;
		endcase
		if (state_q == ST_IDLE) begin
			mul_a      = base_value[W-1:0];
			mul_addend = one_red;
		end else if (state_q == ST_SCAN && exp_q[0]) begin
			mul_a      = r_q;
			mul_addend = b_q;
		end else begin
			mul_a      = b_q;
			mul_addend = b_q;
		end
	end

	mexp_mulmod #(
		.W(W)
	) u_mulmod (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (mul_start),
		.mul_a      (mul_a),
		.mul_addend (mul_addend),
		.mod_ext    (mod_ext),
		.status     (mul_status),
		.result     (mul_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_REDUCE;
			modulus_q   <= 32'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				modulus_q <= modulus;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MUL;
						op_q    <= OP_REDUCE;
					end
				end
				ST_MUL: begin
					if (mul_status.done) begin
						if (op_q == OP_MULR) begin
							op_q <= OP_SQUARE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (exp_q == '0) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_MUL;
						op_q    <= exp_q[0] ? OP_MULR : OP_SQUARE;
					end
				end
				ST_FINISH: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			exp_q <= exponent_value[W-1:0];
			r_q   <= W'(1);
		end else if (state_q == ST_MUL && mul_status.done) begin
			case (op_q)
				OP_REDUCE: b_q <= mul_result;
				OP_MULR:   r_q <= mul_result;
				OP_SQUARE: begin
					b_q   <= mul_result;
					exp_q <= {1'b0, exp_q[W-1:1]};
				end
				default:   b_q <= mul_result;
			endcase
		end
		if (load_out) begin
			out_data_q <= 32'(r_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign power_result = out_data_q;

endmodule

FILE: dv/modular_exponentiation_top_tb.sv
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives base and exponent transactions and modulus writes into the block. It
// predicts every power_result with its own square-and-multiply model and
// compares each result in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module modular_exponentiation_top_tb;

	localparam int OPW = 32;
	localparam int SETTLE_CYCLES = 2500;

	typedef struct packed {
		logic        set_modulus;
		logic [31:0] mod_value;
		logic [31:0] base;
		logic [31:0] expo;
	} job_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] modulus = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] base_value = '0;
	logic [31:0] exponent_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] power_result;

	job_t        job_q[$];
	logic [31:0] power_q[$];
	logic [31:0] mod_now = 32'd1;
	int          outstanding = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          errors = 0;
	int          powers_sent = 0;
	int          modulus_writes = 0;
	int          results_seen = 0;
	logic        calm = 1'b0;

	modular_exponentiation_top #(
		.OPERAND_WIDTH(OPW)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.modulus       (modulus),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.base_value    (base_value),
		.exponent_value(exponent_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.power_result  (power_result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// A modulus of zero stands for 2 to the operand width, which is a plain wrap.
	function automatic logic [63:0] mod_reduce(input logic [63:0] v, input logic [63:0] m);
		logic [63:0] wmask;
		wmask = (64'd1 << OPW) - 64'd1;
		if (m == 64'd0)
			return v & wmask;
		return v % m;
	endfunction

	function automatic logic [31:0] mod_pow(input logic [31:0] b_in, input logic [31:0] e_in,
			input logic [31:0] m_in);
		logic [63:0] wmask;
		logic [63:0] m;
		logic [63:0] b;
		logic [63:0] e;
		logic [63:0] r;
		wmask = (64'd1 << OPW) - 64'd1;
		m = {32'd0, m_in} & wmask;
		b = mod_reduce({32'd0, b_in} & wmask, m);
		e = {32'd0, e_in} & wmask;
		r = 64'd1;
		while (e != 64'd0) begin
			if (e[0])
				r = mod_reduce(r * b, m);
			e = e >> 1;
			b = mod_reduce(b * b, m);
		end
		return r[31:0];
	endfunction

	task automatic add_modulus(input logic [31:0] m);
		job_t j;
		j = '0;
		j.set_modulus = 1'b1;
		j.mod_value = m;
		job_q.push_back(j);
	endtask

	task automatic add_power(input logic [31:0] b, input logic [31:0] e);
		job_t j;
		j = '0;
		j.base = b;
		j.expo = e;
		job_q.push_back(j);
	endtask

	// A modulus write waits until every result of the previous phase is back.
	always @(posedge clk) begin : drive
		logic in_hold;
		logic cfg_hold;
		logic in_done;
		job_t job;
		if (arst_n) begin
			in_done = in_valid && in_ready;
			in_hold = in_valid && !in_ready;
			cfg_hold = cfg_valid && !cfg_ready;
			if (!in_hold && !cfg_hold) begin
				if (gap_left != 0) begin
					gap_left = gap_left - 1;
					in_valid <= 1'b0;
					cfg_valid <= 1'b0;
				end else if (job_q.size() != 0 &&
						(!job_q[0].set_modulus || (outstanding == 0 && !in_done))) begin
					job = job_q.pop_front();
					if (job.set_modulus) begin
						cfg_valid <= 1'b1;
						modulus <= job.mod_value;
						in_valid <= 1'b0;
					end else begin
						in_valid <= 1'b1;
						base_value <= job.base;
						exponent_value <= job.expo;
						cfg_valid <= 1'b0;
					end
					if (!calm && $urandom_range(0, 3) == 0)
						gap_left = $urandom_range(1, 5);
				end else begin
					in_valid <= 1'b0;
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : watch
		logic [31:0] want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				mod_now = modulus;
				modulus_writes++;
			end
			if (in_valid && in_ready) begin
				power_q.push_back(mod_pow(base_value, exponent_value, mod_now));
				powers_sent++;
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (power_q.size() == 0) begin
					$error("power_result %h arrived with no transaction pending", power_result);
					errors++;
				end else begin
					want = power_q.pop_front();
					if (power_result !== want) begin
						$error("power_result: expected %h, actual %h", want, power_result);
						errors++;
					end
				end
			end
			outstanding <= power_q.size();
			if (stall_left != 0) begin
				stall_left = stall_left - 1;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 5) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : run
		logic [31:0] m;
		logic [31:0] b;
		logic [31:0] e;
		int n;

		// The reset modulus of 1 is used first, then the extremes and a prime.
		add_power(32'd5, 32'd0);
		add_power(32'd5, 32'd3);
		add_modulus(32'hFFFF_FFFF);
		add_power(32'd0, 32'd0);
		add_power(32'd0, 32'd1);
		add_power(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_power(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		add_power(32'd2, 32'hFFFF_FFFF);
		add_power(32'hDEAD_BEEF, 32'd1);
		add_modulus(32'd0);
		add_power(32'd3, 32'hFFFF_FFFF);
		add_power(32'hFFFF_FFFF, 32'd2);
		add_power(32'd2, 32'd32);
		add_power(32'd2, 32'd31);
		add_modulus(32'd1);
		add_power(32'd0, 32'd0);
		add_power(32'd7, 32'hFFFF_FFFF);
		add_modulus(32'hFFFF_FFFB);
		add_power(32'hFFFF_FFFA, 32'hFFFF_FFFA);
		add_power(32'hFFFF_FFFB, 32'd5);
		add_power(32'd12345, 32'h8000_0000);
		add_modulus(32'd2);
		add_power(32'd3, 32'd1);
		add_power(32'd4, 32'd7);

		for (int ph = 0; ph < 10; ph++) begin
			case ($urandom_range(0, 4))
				0: m = $urandom;
				1: m = $urandom_range(1, 255);
				2: m = 32'hFFFF_FFFF - $urandom_range(0, 255);
				3: m = 32'd1 << $urandom_range(0, 31);
				default: m = $urandom | 32'h8000_0001;
			endcase
			if (ph == 2)
				m = 32'd0;
			add_modulus(m);
			n = $urandom_range(22, 30);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 9))
					0: b = 32'd0;
					1: b = 32'hFFFF_FFFF;
					2: b = m - 32'd1;
					3: b = m + $urandom_range(0, 2);
					default: b = $urandom;
				endcase
				case ($urandom_range(0, 9))
					0: e = $urandom_range(0, 15);
					1: e = $urandom >> $urandom_range(0, 31);
					2: e = 32'hFFFF_FFFF;
					default: e = $urandom;
				endcase
				add_power(b, e);
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (job_q.size() > 40)
			@(negedge clk);
		calm = 1'b1;
		while (job_q.size() != 0 || in_valid || cfg_valid || outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Ran %0d exponentiations across %0d modulus writes, including wrap mode.",
			powers_sent, modulus_writes);
		$display("Checked %0d results with random stalls on both channels.", results_seen);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
